>>> rtl/core/ngram_pool_lru_table_assert.svh
// Assertion macros used by the n-gram pool engine.
`ifndef NGRAM_POOL_LRU_TABLE_ASSERT_SVH
`define NGRAM_POOL_LRU_TABLE_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define NPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the following cycle.
`define NPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/npl_pkg.sv
// Shared types and codes of the n-gram pool table.
package npl_pkg;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned FIELDS = 3;
  localparam int unsigned CNT_BITS = 4;
  localparam int unsigned POOL_DEPTH = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GUESS  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [KEY_BITS-1:0]   key;
    logic [FIELD_BITS-1:0] tok_a;
    logic [FIELD_BITS-1:0] tok_b;
    logic [FIELD_BITS-1:0] tok_c;
    logic [CNT_BITS-1:0]   guess_count;
  } req_t;
endpackage

>>> rtl/core/npl_front.sv
// Request front end: mask tokens, drop unused codes, two-entry queue.
module npl_front import npl_pkg::*; #(
  parameter int unsigned TOKEN_BITS = 16,
  parameter int unsigned NGRAM_LEN  = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output req_t q_req_o
);
  localparam int unsigned TB = (TOKEN_BITS < FIELD_BITS) ? TOKEN_BITS : FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] TMASK = FIELD_BITS'((17'd1 << TB) - 17'd1);

  req_t slot_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t clean;
  logic push, pop;

  always_comb begin
    clean = req_i;
    clean.tok_a = (NGRAM_LEN > 0) ? (req_i.tok_a & TMASK) : '0;
    clean.tok_b = (NGRAM_LEN > 1) ? (req_i.tok_b & TMASK) : '0;
    clean.tok_c = (NGRAM_LEN > 2) ? (req_i.tok_c & TMASK) : '0;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  // Unused op codes are dropped here without entering the queue.
  assign push = in_valid_i && in_ready_o && (req_i.op != OP_NONE);
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= clean;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/core/npl_back.sv
// Pool engine: count table with epoch marks, entry memory, insert, guess and clear sequencer.
module npl_back import npl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [CNT_BITS-1:0] pool_size_i,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  req_t q_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic hit_o,
  output logic [FIELD_BITS-1:0] out_a_o,
  output logic [FIELD_BITS-1:0] out_b_o,
  output logic [FIELD_BITS-1:0] out_c_o,
  output logic last_o
);
`include "ngram_pool_lru_table_assert.svh"
  localparam int unsigned SB = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned AB = KEY_BITS + SB;
  localparam int unsigned EB = FIELDS * FIELD_BITS;
  localparam int unsigned EPB = 8;
  localparam int unsigned CW = CNT_BITS + EPB;
  localparam logic [CNT_BITS:0] DEPTH_C = (CNT_BITS+1)'(POOL_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CNT   = 8'b00000010,
    S_RD    = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_APP   = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_WAIT  = 8'b01000000,
    S_SWEEP = 8'b10000000
  } state_e;

  // Count table: count plus the epoch it was written in; an older epoch reads as empty.
  logic [CW-1:0] cnt_mem [1<<KEY_BITS];
  logic [EB-1:0] ent_mem [1<<AB];
  logic [CW-1:0] cnt_rd_q;
  logic [EB-1:0] ent_rd_q;
  logic [EPB-1:0] epoch_q;
  logic [KEY_BITS-1:0] sw_q;
  state_e st_q, st_d;
  req_t r_q;
  logic [CNT_BITS:0] cnt_q, rd_q, wr_q, n_q, k_q;
  logic drop_q;
  logic [CNT_BITS:0] cnt_d, rd_d, wr_d, n_d, k_d;
  logic drop_d;
  logic [CNT_BITS:0] limit, want, mem_cnt, take, wr_eff;
  logic cnt_we, ent_we, ent_rd_en;
  logic [KEY_BITS-1:0] cnt_wa;
  logic [CW-1:0] cnt_wd;
  logic [AB-1:0] ent_wa, ent_ra;
  logic [EB-1:0] ent_wd, gram;
  logic ob_valid_q, ob_hit_q, ob_last_q;
  logic [EB-1:0] ob_data_q;
  logic ob_load, ob_take;

  assign gram = {r_q.tok_c, r_q.tok_b, r_q.tok_a};
  assign q_ready_o = (st_q == S_IDLE);
  assign limit = ({1'b0, pool_size_i} > DEPTH_C) ? DEPTH_C : {1'b0, pool_size_i};
  assign want = {1'b0, r_q.guess_count};
  assign take = (want < mem_cnt) ? want : mem_cnt;
  assign ent_ra = {r_q.key, rd_q[SB-1:0]};
  // Hold the read data while a result waits for the output register.
  assign ent_rd_en = (st_q == S_RD) || (st_q == S_SCAN);
  assign ob_take = out_valid_o && out_ready_i;
  // In the drop pass slot 0 is skipped, so every later slot lands one lower.
  assign wr_eff = (drop_q && wr_q != '0) ? wr_q - 1'b1 : wr_q;

  always_comb begin
    mem_cnt = (cnt_rd_q[CW-1 -: EPB] == epoch_q) ? {1'b0, cnt_rd_q[CNT_BITS-1:0]} : '0;
    if (mem_cnt > DEPTH_C) mem_cnt = DEPTH_C;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE) cnt_rd_q <= cnt_mem[q_req_i.key];
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (ent_rd_en) ent_rd_q <= ent_mem[ent_ra];
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
  end

  // Sequencer. Insert: stream slots, compact out matches, then drop oldest if full.
  always_comb begin
    st_d = st_q;
    rd_d = rd_q; wr_d = wr_q; cnt_d = cnt_q; n_d = n_q; k_d = k_q; drop_d = drop_q;
    cnt_we = 1'b0; cnt_wa = r_q.key; cnt_wd = '0;
    ent_we = 1'b0; ent_wa = {r_q.key, wr_eff[SB-1:0]}; ent_wd = ent_rd_q;
    ob_load = 1'b0;
    case (st_q)
      S_IDLE: if (q_valid_i) st_d = S_CNT;
      S_CNT: begin
        cnt_d = mem_cnt;
        rd_d = '0; wr_d = '0; drop_d = 1'b0;
        case (r_q.op)
          // the epoch is about to wrap: zero every count before it is reused
          OP_CLEAR: st_d = (epoch_q == '1) ? S_SWEEP : S_IDLE;
          OP_INSERT: st_d = (limit == '0) ? S_IDLE : ((mem_cnt == '0) ? S_APP : S_RD);
          OP_GUESS: begin
            n_d = take;
            rd_d = mem_cnt - take;
            k_d = '0;
            st_d = (take == '0) ? S_WAIT : S_RD;
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_RD: begin
        rd_d = rd_q + 1'b1;
        st_d = (r_q.op == OP_INSERT) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        // ent_rd_q holds slot rd_q-1; keep it unless it equals the new n-gram
        if (ent_rd_q != gram) begin
          ent_we = !(drop_q && wr_q == '0);
          wr_d = wr_q + 1'b1;
        end
        if (rd_q == cnt_q) st_d = S_APP;
        else rd_d = rd_q + 1'b1;
      end
      S_APP: begin
        if (!drop_q && wr_q >= limit && wr_q != '0) begin
          // full: rescan once with the oldest slot dropped
          st_d = S_RD; rd_d = '0; wr_d = '0; drop_d = 1'b1;
          cnt_d = wr_q;
        end else begin
          ent_we = 1'b1; ent_wd = gram;
          cnt_we = 1'b1;
          cnt_wd = {epoch_q, CNT_BITS'(wr_eff + 1'b1)};
          st_d = S_IDLE;
        end
      end
      S_EMIT: if (!ob_valid_q || ob_take) begin
        ob_load = 1'b1;
        k_d = k_q + 1'b1;
        st_d = (k_q + 1'b1 == n_q) ? S_IDLE : S_RD;
      end
      S_WAIT: if (!ob_valid_q || ob_take) begin
        ob_load = 1'b1;
        st_d = S_IDLE;
      end
      S_SWEEP: begin
        cnt_we = 1'b1; cnt_wa = sw_q; cnt_wd = '0;
        if (sw_q == '1) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) r_q <= q_req_i;
    if (ob_load) begin
      ob_hit_q <= (st_q == S_EMIT);
      ob_data_q <= (st_q == S_EMIT) ? ent_rd_q : '0;
      ob_last_q <= (st_q == S_WAIT) || (k_q + 1'b1 == n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_SWEEP;
      epoch_q <= '0;
      sw_q <= '0;
      ob_valid_q <= 1'b0;
      cnt_q <= '0; rd_q <= '0; wr_q <= '0; n_q <= '0; k_q <= '0; drop_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; rd_q <= rd_d; wr_q <= wr_d; n_q <= n_d; k_q <= k_d;
      drop_q <= drop_d;
      if (st_q == S_CNT && r_q.op == OP_CLEAR) epoch_q <= epoch_q + 1'b1;
      if (st_q == S_SWEEP) sw_q <= sw_q + 1'b1;
      if (ob_load) ob_valid_q <= 1'b1;
      else if (ob_take) ob_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = ob_valid_q;
  assign hit_o = ob_hit_q;
  assign out_a_o = ob_data_q[0 +: FIELD_BITS];
  assign out_b_o = ob_data_q[FIELD_BITS +: FIELD_BITS];
  assign out_c_o = ob_data_q[2*FIELD_BITS +: FIELD_BITS];
  assign last_o = ob_last_q;

  `NPL_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(st_q), "state not one-hot")
  `NPL_ASSERT_IMP(a_miss_last, clk_i, rst_ni, out_valid_o && !hit_o, last_o,
                  "empty answer without last")
  `NPL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(ob_data_q), "result changed while stalled")
endmodule

>>> rtl/core/ngram_pool_lru_table.sv
// Top level of the n-gram pool table.
// Per-key pools of recent n-grams, oldest first. A front queue takes requests
// into two registered slots and passes them on to the pool engine when it is
// idle. An insert streams the key's slots once from the entry memory,
// compacting out a match. When the compacted pool is still full, one more
// pass drops the oldest. A guess returning n results reads them one at a
// time, and a result that waits at the output stalls the engine. A miss or a
// zero count gives one result. A clear bumps the epoch mark that count table
// entries are checked against; after reset, and after every 256th clear when
// the mark wraps, the engine zeroes the whole count table before it takes the
// next request. The engine handles one request at a time; the queue holds two
// more.
module ngram_pool_lru_table import npl_pkg::*; #(
  parameter int unsigned TOKEN_BITS = 16,
  parameter int unsigned NGRAM_LEN  = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CNT_BITS-1:0] cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] op_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [FIELD_BITS-1:0] tok_a_i,
  input  logic [FIELD_BITS-1:0] tok_b_i,
  input  logic [FIELD_BITS-1:0] tok_c_i,
  input  logic [CNT_BITS-1:0] guess_count_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic hit_o,
  output logic [FIELD_BITS-1:0] out_a_o,
  output logic [FIELD_BITS-1:0] out_b_o,
  output logic [FIELD_BITS-1:0] out_c_o,
  output logic last_o
);
  logic [CNT_BITS-1:0] pool_size_q;
  req_t req, q_req;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pool_size_q <= '0;
    else if (cfg_we_i) pool_size_q <= cfg_wdata_i;
  end

  always_comb begin
    req.op = op_e'(op_i);
    req.key = key_i;
    req.tok_a = tok_a_i;
    req.tok_b = tok_b_i;
    req.tok_c = tok_c_i;
    req.guess_count = guess_count_i;
  end

  npl_front #(.TOKEN_BITS(TOKEN_BITS), .NGRAM_LEN(NGRAM_LEN)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_i(req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  npl_back u_back (
    .clk_i, .rst_ni, .pool_size_i(pool_size_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .hit_o, .out_a_o, .out_b_o, .out_c_o, .last_o
  );
endmodule
